/* hdl/drmt_pkg.sv */
// shared types and constants of the dirty rectangle mailbox tracker
`default_nettype none
package drmt_pkg;

  // field widths
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = 28;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // frame size after reset
  localparam logic [DIM_W-1:0] FRAME_RESET = 13'd4096;

  // result status codes
  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_REJECTED = 3'd2,
    ST_CONSUMED = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  // classification done by the front end
  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_IGNORE,
    CMD_REJECT,
    CMD_CONSUME
  } cmd_kind_t;

  // input item
  typedef struct packed {
    logic              op;
    logic [DIM_W-1:0]  rect_x;
    logic [DIM_W-1:0]  rect_y;
    logic [DIM_W-1:0]  rect_w;
    logic [DIM_W-1:0]  rect_h;
    logic [15:0]       row_stride;
    logic [31:0]       source_bytes;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]        status;
    logic [POS_W-1:0]  out_x;
    logic [POS_W-1:0]  out_y;
    logic [DIM_W-1:0]  out_w;
    logic [DIM_W-1:0]  out_h;
    logic              is_pending;
    logic [31:0]       submitted_count;
    logic [31:0]       replaced_count;
    logic [31:0]       consumed_count;
    logic [47:0]       bytes_count;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [PROD_W-1:0] bytes;
  } cmd_t;

endpackage
`default_nettype wire

/* hdl/dirty_rect_mailbox_tracker_core.sv */
// path: the item is registered in the command queue and its result in the result queue
// throughput: one item per cycle while neither queue is full; the front checks and
//   the back merge are combinational, decoupled by a command queue and a result queue
// full is the command queue's full flag and rises only while the result queue is full
// reset: synchronous active-low rst_n clears the region, counters and queues
//   and sets the frame size to 4096 by 4096
`default_nettype none
module dirty_rect_mailbox_tracker_core #(
  parameter int unsigned MAX_DIM     = 4096,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire drmt_pkg::in_item_t             in_data,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output drmt_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [drmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [drmt_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int unsigned CMD_W = $bits(drmt_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(drmt_pkg::out_item_t);

  drmt_pkg::cmd_t      front_cmd;
  drmt_pkg::cmd_t      back_cmd;
  logic [CMD_W-1:0]    back_cmd_bits;
  logic                cmd_empty;
  logic                cmd_pop;
  drmt_pkg::out_item_t back_res;
  logic                res_push;
  logic                res_full;
  logic [RES_W-1:0]    out_bits;

  // classify the incoming item
  drmt_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (in_data),
    .cmd       (front_cmd)
  );

  // command queue
  drmt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (back_cmd_bits),
    .empty (cmd_empty)
  );

  assign back_cmd = drmt_pkg::cmd_t'(back_cmd_bits);

  // apply the command to the pending region
  drmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // result queue
  drmt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_bits),
    .empty (out_empty)
  );

  assign out_data = drmt_pkg::out_item_t'(out_bits);

`ifndef SYNTHESIS
  // an accepted item reaches the command queue
  a_cmd_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !cmd_empty)
    else $error("accepted item missing from command queue");

  // a processed command always yields a waiting result
  a_res_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd_empty && !res_full) |=> !out_empty)
    else $error("processed command produced no result");

  // a consume never leaves a frame pending
  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (back_res.status == drmt_pkg::ST_CONSUMED ||
                  back_res.status == drmt_pkg::ST_NONE)) |-> !back_res.is_pending)
    else $error("frame still pending after consume");

  // a stored rectangle always leaves a frame pending
  a_store_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && back_res.status == drmt_pkg::ST_STORED) |-> back_res.is_pending)
    else $error("stored rectangle not pending");
`endif

endmodule
`default_nettype wire

/* hdl/drmt_fifo.sv */
// small first-in first-out queue used between the pipeline parts
`default_nettype none
module drmt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  // status and read side
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // pointers wrap at the last entry, fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/drmt_front.sv */
// front end: frame size registers, bounds checks and byte count of an item
`default_nettype none
module drmt_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [drmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [drmt_pkg::DIM_W-1:0]      cfg_wdata,
  input  wire drmt_pkg::in_item_t              item,
  output drmt_pkg::cmd_t                       cmd
);

  localparam logic [drmt_pkg::DIM_W-1:0] MAX_DIM_V = drmt_pkg::DIM_W'(MAX_DIM);

  logic [drmt_pkg::DIM_W-1:0] frame_width_r;
  logic [drmt_pkg::DIM_W-1:0] frame_height_r;
  logic [drmt_pkg::DIM_W-1:0] w;
  logic [drmt_pkg::DIM_W-1:0] h;
  logic [drmt_pkg::DIM_W-1:0] w_room;
  logic [drmt_pkg::DIM_W-1:0] h_room;
  logic [15:0]                min_stride;
  logic [28:0]                min_src;
  logic [25:0]                area;
  logic                       is_empty;
  logic                       is_oob;

  // frame size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= drmt_pkg::FRAME_RESET;
      frame_height_r <= drmt_pkg::FRAME_RESET;
    end else if (cfg_we) begin
      if (cfg_index == drmt_pkg::REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_wdata;
      end else if (cfg_index == drmt_pkg::REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_wdata;
      end
    end
  end

  // effective frame size, zero taken as one and large values capped
  always_comb begin
    if (frame_width_r == '0) begin
      w = drmt_pkg::DIM_W'(1);
    end else if (frame_width_r > MAX_DIM_V) begin
      w = MAX_DIM_V;
    end else begin
      w = frame_width_r;
    end
    if (frame_height_r == '0) begin
      h = drmt_pkg::DIM_W'(1);
    end else if (frame_height_r > MAX_DIM_V) begin
      h = MAX_DIM_V;
    end else begin
      h = frame_height_r;
    end
  end

  // bounds and source size checks
  assign w_room     = w - item.rect_x;
  assign h_room     = h - item.rect_y;
  assign min_stride = {1'b0, w, 2'b00};
  assign min_src    = 29'(item.row_stride) * 29'(h);
  assign area       = 26'(item.rect_w) * 26'(item.rect_h);
  assign is_empty   = (item.rect_w == '0) || (item.rect_h == '0);
  assign is_oob     = (item.rect_x >= w) || (item.rect_y >= h) ||
                      (item.rect_w > w_room) || (item.rect_h > h_room) ||
                      (item.row_stride < min_stride) ||
                      (item.source_bytes < {3'b000, min_src});

  // classified command
  always_comb begin
    cmd.x     = item.rect_x[drmt_pkg::POS_W-1:0];
    cmd.y     = item.rect_y[drmt_pkg::POS_W-1:0];
    cmd.w     = item.rect_w;
    cmd.h     = item.rect_h;
    cmd.bytes = {area, 2'b00};
    priority if (item.op) begin
      cmd.kind = drmt_pkg::CMD_CONSUME;
    end else if (is_empty) begin
      cmd.kind = drmt_pkg::CMD_IGNORE;
    end else if (is_oob) begin
      cmd.kind = drmt_pkg::CMD_REJECT;
    end else begin
      cmd.kind = drmt_pkg::CMD_STORE;
    end
  end

endmodule
`default_nettype wire

/* hdl/drmt_back.sv */
// back end: pending region, bounding-box merge and statistics counters
`default_nettype none
module drmt_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire drmt_pkg::cmd_t cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output drmt_pkg::out_item_t res
);

  logic                       pending_r, pending_nxt;
  logic [drmt_pkg::POS_W-1:0] left_r, left_nxt;
  logic [drmt_pkg::POS_W-1:0] top_r, top_nxt;
  logic [drmt_pkg::DIM_W-1:0] span_x_r, span_x_nxt;
  logic [drmt_pkg::DIM_W-1:0] span_y_r, span_y_nxt;
  logic [31:0]                submit_r, submit_nxt;
  logic [31:0]                replace_r, replace_nxt;
  logic [31:0]                consume_r, consume_nxt;
  logic [47:0]                bytes_r, bytes_nxt;
  logic [drmt_pkg::POS_W-1:0] nx, ny;
  logic [13:0]                right, bottom;
  logic [13:0]                right_new, right_old, bottom_new, bottom_old;
  drmt_pkg::status_t          status;
  logic                       show;
  logic                       fire;

  assign fire     = !cmd_empty && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  // union of the new rectangle with the pending one
  always_comb begin
    right_new  = 14'(cmd.x) + 14'(cmd.w);
    bottom_new = 14'(cmd.y) + 14'(cmd.h);
    right_old  = 14'(left_r) + 14'(span_x_r);
    bottom_old = 14'(top_r) + 14'(span_y_r);
    nx         = (cmd.x < left_r) ? cmd.x : left_r;
    ny         = (cmd.y < top_r) ? cmd.y : top_r;
    right      = (right_new > right_old) ? right_new : right_old;
    bottom     = (bottom_new > bottom_old) ? bottom_new : bottom_old;
  end

  // next state and status
  always_comb begin
    pending_nxt = pending_r;
    left_nxt    = left_r;
    top_nxt     = top_r;
    span_x_nxt  = span_x_r;
    span_y_nxt  = span_y_r;
    submit_nxt  = submit_r;
    replace_nxt = replace_r;
    consume_nxt = consume_r;
    bytes_nxt   = bytes_r;
    status      = drmt_pkg::ST_IGNORED;
    unique case (cmd.kind)
      drmt_pkg::CMD_STORE: begin
        status      = drmt_pkg::ST_STORED;
        bytes_nxt   = bytes_r + 48'(cmd.bytes);
        submit_nxt  = submit_r + 32'd1;
        pending_nxt = 1'b1;
        if (pending_r) begin
          replace_nxt = replace_r + 32'd1;
          left_nxt    = nx;
          top_nxt     = ny;
          span_x_nxt  = drmt_pkg::DIM_W'(right - 14'(nx));
          span_y_nxt  = drmt_pkg::DIM_W'(bottom - 14'(ny));
        end else begin
          left_nxt   = cmd.x;
          top_nxt    = cmd.y;
          span_x_nxt = cmd.w;
          span_y_nxt = cmd.h;
        end
      end
      drmt_pkg::CMD_IGNORE: begin
        status = drmt_pkg::ST_IGNORED;
      end
      drmt_pkg::CMD_REJECT: begin
        status = drmt_pkg::ST_REJECTED;
      end
      drmt_pkg::CMD_CONSUME: begin
        if (pending_r) begin
          status      = drmt_pkg::ST_CONSUMED;
          pending_nxt = 1'b0;
          consume_nxt = consume_r + 32'd1;
        end else begin
          status = drmt_pkg::ST_NONE;
        end
      end
      default: begin
        status = drmt_pkg::ST_IGNORED;
      end
    endcase
  end

  // result item, region zeroed when nothing is shown
  always_comb begin
    show                = pending_nxt || (status == drmt_pkg::ST_CONSUMED);
    res.status          = status;
    res.out_x           = show ? left_nxt : '0;
    res.out_y           = show ? top_nxt : '0;
    res.out_w           = show ? span_x_nxt : '0;
    res.out_h           = show ? span_y_nxt : '0;
    res.is_pending      = pending_nxt;
    res.submitted_count = submit_nxt;
    res.replaced_count  = replace_nxt;
    res.consumed_count  = consume_nxt;
    res.bytes_count     = bytes_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      left_r    <= '0;
      top_r     <= '0;
      span_x_r  <= '0;
      span_y_r  <= '0;
      submit_r  <= '0;
      replace_r <= '0;
      consume_r <= '0;
      bytes_r   <= '0;
    end else if (fire) begin
      pending_r <= pending_nxt;
      left_r    <= left_nxt;
      top_r     <= top_nxt;
      span_x_r  <= span_x_nxt;
      span_y_r  <= span_y_nxt;
      submit_r  <= submit_nxt;
      replace_r <= replace_nxt;
      consume_r <= consume_nxt;
      bytes_r   <= bytes_nxt;
    end
  end

endmodule
`default_nettype wire
